@@ rtl/graphics_tag_packet_unpacker_core_defines.svh @@
// Assertion macros for the checker file of the tag packet unpacker.
`ifndef GRAPHICS_TAG_PACKET_UNPACKER_CORE_DEFINES_SVH
`define GRAPHICS_TAG_PACKET_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define GTPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define GTPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gtpu_pkg.sv @@
package gtpu_pkg;

  typedef struct packed {
    logic [63:0] word_high;
    logic [63:0] word_low;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  register_number;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic        prim_preset;
    logic        packet_end;
    logic        last;
  } out_beat_t;

  localparam logic [1:0] KIND_TAG    = 2'd0;
  localparam logic [1:0] KIND_PACKED = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;
  localparam logic [1:0] KIND_IMAGE  = 2'd3;

  localparam logic [1:0] MODE_PACKED = 2'd0;
  localparam logic [1:0] MODE_LIST   = 2'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  slot;
    logic [14:0] loops;
    logic        pend;
    logic        pkt_end;
  } walk_t;

  // Advances the slot and loop counters by one data item.
  function automatic walk_t walk_item(input logic [3:0] slot, input logic [3:0] regs,
                                      input logic [14:0] loops, input logic pend,
                                      input logic by_slot);
    walk_t      w;
    logic [3:0] nxt;
    logic       done;
    nxt       = slot + 4'd1;
    done      = 1'b1;
    w.slot    = slot;
    w.loops   = loops;
    w.pend    = pend;
    w.pkt_end = 1'b0;
    if (by_slot) begin
      if (nxt == regs) begin
        w.slot = '0;
      end else begin
        w.slot = nxt;
        done   = 1'b0;
      end
    end
    if (done && (loops != '0)) begin
      w.loops = loops - 15'd1;
      if ((w.loops == '0) && pend) begin
        w.pend    = 1'b0;
        w.pkt_end = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

@@ rtl/gtpu_step.sv @@
module gtpu_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtpu_pkg::in_beat_t  beat_i,
  input  logic                advance_i,
  output gtpu_pkg::out_beat_t res0_o,
  output gtpu_pkg::out_beat_t res1_o,
  output logic                two_o
);
  import gtpu_pkg::*;

  logic [14:0] loops_q, loops_d;
  logic [1:0]  mode_q, mode_d;
  logic [3:0]  regs_q, regs_d;
  logic [63:0] list_q, list_d;
  logic [3:0]  slot_q, slot_d;
  logic        pend_q, pend_d;

  walk_t      w0, w1;
  logic       by_slot;
  logic [3:0] reg0, reg1;

  assign by_slot = (mode_q == MODE_PACKED) || (mode_q == MODE_LIST);
  assign w0      = walk_item(slot_q, regs_q, loops_q, pend_q, by_slot);
  assign w1      = walk_item(w0.slot, regs_q, w0.loops, w0.pend, 1'b1);
  assign reg0    = list_q[{slot_q, 2'b00} +: 4];
  assign reg1    = list_q[{w0.slot, 2'b00} +: 4];

  always_comb begin
    res0_o  = '0;
    res1_o  = '0;
    two_o   = 1'b0;
    loops_d = loops_q;
    mode_d  = mode_q;
    regs_d  = regs_q;
    list_d  = list_q;
    slot_d  = slot_q;
    pend_d  = pend_q;
    if (loops_q == '0) begin
      loops_d             = beat_i.word_low[14:0];
      mode_d              = beat_i.word_low[59:58];
      regs_d              = beat_i.word_low[63:60];
      list_d              = beat_i.word_high;
      slot_d              = '0;
      pend_d              = beat_i.word_low[15] && (beat_i.word_low[14:0] != '0);
      res0_o.kind         = KIND_TAG;
      res0_o.payload_low  = {53'd0, beat_i.word_low[57:47]};
      res0_o.prim_preset  = beat_i.word_low[46];
      res0_o.packet_end   = beat_i.word_low[15] && (beat_i.word_low[14:0] == '0);
      res0_o.last         = 1'b1;
    end else begin
      loops_d = w0.loops;
      slot_d  = w0.slot;
      pend_d  = w0.pend;
      case (mode_q)
        MODE_PACKED: begin
          res0_o.kind            = KIND_PACKED;
          res0_o.register_number = reg0;
          res0_o.payload_low     = beat_i.word_low;
          res0_o.payload_high    = beat_i.word_high;
          res0_o.packet_end      = w0.pkt_end;
          res0_o.last            = 1'b1;
        end
        MODE_LIST: begin
          res0_o.kind            = KIND_LIST;
          res0_o.register_number = reg0;
          res0_o.payload_low     = beat_i.word_low;
          res0_o.packet_end      = w0.pkt_end;
          if (w0.loops != '0) begin
            two_o                  = 1'b1;
            res1_o.kind            = KIND_LIST;
            res1_o.register_number = reg1;
            res1_o.payload_low     = beat_i.word_high;
            res1_o.packet_end      = w1.pkt_end;
            res1_o.last            = 1'b1;
            loops_d                = w1.loops;
            slot_d                 = w1.slot;
            pend_d                 = w1.pend;
          end else begin
            res0_o.last = 1'b1;
          end
        end
        default: begin
          res0_o.kind         = KIND_IMAGE;
          res0_o.payload_low  = beat_i.word_low;
          res0_o.payload_high = beat_i.word_high;
          res0_o.packet_end   = w0.pkt_end;
          res0_o.last         = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loops_q <= '0;
      mode_q  <= '0;
      regs_q  <= '0;
      list_q  <= '0;
      slot_q  <= '0;
      pend_q  <= 1'b0;
    end else if (advance_i) begin
      loops_q <= loops_d;
      mode_q  <= mode_d;
      regs_q  <= regs_d;
      list_q  <= list_d;
      slot_q  <= slot_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ rtl/gtpu_result_fifo.sv @@
module gtpu_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr0_i,
  input  logic                wr1_i,
  input  gtpu_pkg::out_beat_t data0_i,
  input  gtpu_pkg::out_beat_t data1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gtpu_pkg::out_beat_t out_beat_o
);
  import gtpu_pkg::*;

  out_beat_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd;

  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = mem_q[rptr_q];
  assign rd          = out_valid_o && !out_stall_i;
  assign room2_o     = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + PTR_W'(wr0_i) + PTR_W'(wr1_i);
    rptr_d = rptr_q + PTR_W'(rd);
    cnt_d  = cnt_q + CNT_W'(wr0_i) + CNT_W'(wr1_i) - CNT_W'(rd);
  end

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (wr1_i) begin
      mem_q[wptr_q + PTR_W'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ rtl/graphics_tag_packet_unpacker_core.sv @@
// Unpacks a stream of 128-bit quadwords into tag, register and image beats. A quadword
// that arrives when no loops remain is decoded as a tag and yields one tag beat; later
// quadwords yield one packed-register beat, one image beat, or two list-register beats
// (one if the low half ends the last loop). A quadword can be taken every cycle while the
// input does not stall: it is held in the input register, decoded from there and written
// into a four-entry result queue once the queue has room for two beats, and its first beat
// can be offered in the cycle after it is written. The result port issues one beat per
// cycle while out_stall_i is low, so list quadwords, which yield two beats each, sustain
// half that rate and all other quadwords one per cycle. The input stalls while a quadword
// waits in the input register and the queue has room for fewer than two beats.
module graphics_tag_packet_unpacker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gtpu_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gtpu_pkg::out_beat_t out_beat_o
);
  import gtpu_pkg::*;

  logic      in_vld_q, in_vld_d;
  in_beat_t  in_beat_q;
  logic      consume, room2, two;
  out_beat_t res0, res1;

  assign consume    = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !consume;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_beat_q <= in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  gtpu_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (in_beat_q),
    .advance_i (consume),
    .res0_o    (res0),
    .res1_o    (res1),
    .two_o     (two)
  );

  gtpu_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr0_i       (consume),
    .wr1_i       (consume && two),
    .data0_i     (res0),
    .data1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ rtl/gtpu_checker.sv @@
`include "graphics_tag_packet_unpacker_core_defines.svh"

module gtpu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input gtpu_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gtpu_pkg::out_beat_t out_beat_o
);
  import gtpu_pkg::*;

  logic single_kind;
  logic single_out;
  logic out_hold;
  logic out_mid;
  logic list_beat;
  logic in_hold;

  assign single_kind = (out_beat_o.kind == KIND_TAG) || (out_beat_o.kind == KIND_PACKED) ||
                       (out_beat_o.kind == KIND_IMAGE);
  assign single_out  = out_valid_o && single_kind;
  assign out_hold    = out_valid_o && out_stall_i;
  assign out_mid     = out_valid_o && !out_stall_i && !out_beat_o.last;
  assign list_beat   = out_valid_o && (out_beat_o.kind == KIND_LIST);
  assign in_hold     = in_valid_i && in_stall_o;

  `GTPU_ASSERT_NEXT(a_in_hold, in_hold, in_valid_i && $stable(in_beat_i), "Input beat changed.")
  `GTPU_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_beat_o), "Beat changed.")
  `GTPU_ASSERT_NEXT(a_list_pair, out_mid, list_beat, "Second list beat did not follow.")
  `GTPU_ASSERT_NOW(a_single_last, single_out, out_beat_o.last, "Single beat without last.")

endmodule

bind graphics_tag_packet_unpacker_core gtpu_checker u_checker (.*);

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtpu_pkg::*;

  localparam logic [1:0] MODE_IMAGE  = 2'd2;
  localparam logic [1:0] MODE_IMAGE2 = 2'd3;
  localparam int IDLE_PCT = 29;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int in_idle_pct   = IDLE_PCT;
  int out_idle_pct  = IDLE_PCT;
  int qw_sent       = 0;
  int beats_checked = 0;
  int tags_seen     = 0;
  int packet_ends   = 0;
  int mismatches    = 0;

  // Shadow of the unpacker state, advanced on every accepted quadword.
  logic [14:0] loops_remaining = '0;
  logic [1:0]  data_mode       = '0;
  logic [3:0]  regs_per_loop   = '0;
  logic [3:0]  slot_pos        = '0;
  logic [63:0] reg_list        = '0;
  logic        end_held        = 1'b0;

  out_beat_t expected_beats[$];

  graphics_tag_packet_unpacker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Steps the slot and loop counters past one data item and returns its packet end flag.
  function automatic logic step_counters(input logic by_slot);
    logic loop_done;
    loop_done = 1'b1;
    if (by_slot) begin
      slot_pos = slot_pos + 4'd1;
      if (slot_pos == regs_per_loop) begin
        slot_pos = '0;
      end else begin
        loop_done = 1'b0;
      end
    end
    if (loop_done && (loops_remaining != '0)) begin
      loops_remaining = loops_remaining - 15'd1;
      if ((loops_remaining == '0) && end_held) begin
        end_held = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void unpack_quadword(input in_beat_t qw);
    out_beat_t first;
    out_beat_t second;
    logic      split;
    first  = '0;
    second = '0;
    split  = 1'b0;
    if (loops_remaining == '0) begin
      first.kind        = KIND_TAG;
      first.payload_low = {53'd0, qw.word_low[57:47]};
      first.prim_preset = qw.word_low[46];
      first.packet_end  = qw.word_low[15] && (qw.word_low[14:0] == '0);
      loops_remaining   = qw.word_low[14:0];
      data_mode         = qw.word_low[59:58];
      regs_per_loop     = qw.word_low[63:60];
      reg_list          = qw.word_high;
      slot_pos          = '0;
      end_held          = qw.word_low[15] && (qw.word_low[14:0] != '0);
    end else if (data_mode == MODE_PACKED) begin
      first.kind            = KIND_PACKED;
      first.register_number = reg_list[{slot_pos, 2'b00} +: 4];
      first.payload_low     = qw.word_low;
      first.payload_high    = qw.word_high;
      first.packet_end      = step_counters(1'b1);
    end else if (data_mode == MODE_LIST) begin
      first.kind            = KIND_LIST;
      first.register_number = reg_list[{slot_pos, 2'b00} +: 4];
      first.payload_low     = qw.word_low;
      first.packet_end      = step_counters(1'b1);
      if (loops_remaining != '0) begin
        split                  = 1'b1;
        second.kind            = KIND_LIST;
        second.register_number = reg_list[{slot_pos, 2'b00} +: 4];
        second.payload_low     = qw.word_high;
        second.packet_end      = step_counters(1'b1);
        second.last            = 1'b1;
      end
    end else begin
      first.kind         = KIND_IMAGE;
      first.payload_low  = qw.word_low;
      first.payload_high = qw.word_high;
      first.packet_end   = step_counters(1'b0);
    end
    first.last = !split;
    expected_beats.push_back(first);
    if (split) begin
      expected_beats.push_back(second);
    end
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_beat);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (want.kind == KIND_TAG) tags_seen++;
        if (want.packet_end) packet_ends++;
        compare_field("kind", 64'(want.kind), 64'(out_beat.kind));
        compare_field("register_number", 64'(want.register_number),
                      64'(out_beat.register_number));
        compare_field("payload_low", want.payload_low, out_beat.payload_low);
        compare_field("payload_high", want.payload_high, out_beat.payload_high);
        compare_field("prim_preset", 64'(want.prim_preset), 64'(out_beat.prim_preset));
        compare_field("packet_end", 64'(want.packet_end), 64'(out_beat.packet_end));
        compare_field("last", 64'(want.last), 64'(out_beat.last));
      end
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_beat_t make_tag(input logic [14:0] nloop, input logic eop,
                                        input logic pre, input logic [10:0] prim,
                                        input logic [1:0] flg, input logic [3:0] nreg,
                                        input logic [63:0] list);
    in_beat_t qw;
    qw.word_low  = {nreg, flg, prim, pre, 30'($urandom()), eop, nloop};
    qw.word_high = list;
    return qw;
  endfunction

  task automatic send_qw(input in_beat_t qw);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= qw;
    do @(posedge clk_i); while (in_stall);
    unpack_quadword(qw);
    qw_sent++;
    @(negedge clk_i);
  endtask

  // Feeds data quadwords until the current tag's loops are used up.
  task automatic send_payload(input bit extremes);
    int idx;
    idx = 0;
    while (loops_remaining != '0) begin
      if (extremes && idx == 0) begin
        send_qw('1);
      end else if (extremes && idx == 1) begin
        send_qw('0);
      end else begin
        send_qw({random_word(), random_word()});
      end
      idx++;
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (expected_beats.size() != 0);
  endtask

  task automatic test_empty_tags();
    send_qw(make_tag(15'd0, 1'b0, 1'b1, 11'h7ff, MODE_PACKED, 4'd5, random_word()));
    send_qw(make_tag(15'd0, 1'b1, 1'b0, 11'h000, MODE_IMAGE2, 4'hf, '1));
  endtask

  task automatic test_packed_mode();
    send_qw(make_tag(15'd1, 1'b1, 1'b1, 11'h2a5, MODE_PACKED, 4'd3, 64'hfedc_ba98_7654_3210));
    send_payload(1'b1);
  endtask

  task automatic test_list_mode();
    send_qw(make_tag(15'd1, 1'b1, 1'b0, 11'h155, MODE_LIST, 4'd3, 64'h0000_0000_0000_0a5c));
    send_payload(1'b1);
    send_qw(make_tag(15'd1, 1'b0, 1'b1, 11'h001, MODE_LIST, 4'd0, 64'h0123_4567_89ab_cdef));
    send_payload(1'b1);
    wait_for_drain();
  endtask

  task automatic test_image_modes();
    send_qw(make_tag(15'd2, 1'b1, 1'b0, 11'h400, MODE_IMAGE, 4'd7, random_word()));
    send_payload(1'b1);
    send_qw(make_tag(15'd1, 1'b0, 1'b1, 11'h3ff, MODE_IMAGE2, 4'd1, random_word()));
    send_payload(1'b0);
  endtask

  task automatic test_random_packets(input int target);
    int          first_qw;
    int          pick;
    logic [1:0]  mode;
    logic [14:0] nloop;
    logic [63:0] lo;
    first_qw = qw_sent;
    while (qw_sent - first_qw < target) begin
      pick = $urandom_range(99);
      mode = 2'($urandom_range(3));
      if (pick < 8) begin
        lo       = random_word();
        lo[14:0] = 15'($urandom_range(2));
        send_qw({random_word(), lo});
      end else begin
        if (pick < 18) begin
          nloop = '0;
        end else if (mode >= MODE_IMAGE && pick >= 94) begin
          nloop = 15'($urandom_range(60, 7));
        end else begin
          nloop = 15'($urandom_range(6, 1));
        end
        send_qw(make_tag(nloop, 1'($urandom()), 1'($urandom()), 11'($urandom()), mode,
                         4'($urandom()), random_word()));
      end
      send_payload(1'b0);
      if ($urandom_range(14) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  task automatic test_back_to_back(input int target);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_packets(target);
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_tags();
    test_packed_mode();
    test_list_mode();
    test_image_modes();
    test_random_packets(430);
    test_back_to_back(70);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d quadwords through tag, packed, list and image modes.", qw_sent);
    $display("Checked %0d beats: %0d tags, %0d with packet end.", beats_checked, tags_seen,
             packet_ends);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ graphics_tag_packet_unpacker_core.f @@
+incdir+rtl
rtl/gtpu_pkg.sv
rtl/gtpu_step.sv
rtl/gtpu_result_fifo.sv
rtl/graphics_tag_packet_unpacker_core.sv
rtl/gtpu_checker.sv
tb/sv/tb.sv
